### hw/rtl/ptba_pkg.sv
// Shared widths, codes and reset values for the per-thread bump allocator.
package ptba_pkg;

  // Build-time defaults for the top-level parameters
  localparam int THREAD_SLOTS_DEF = 16;
  localparam int ADDR_BITS_DEF    = 48;

  // Field widths
  localparam int CMD_W      = 2;
  localparam int SLOT_IN_W  = 4;
  localparam int SIZE_W     = 25;
  localparam int ADDR_OUT_W = 48;
  localparam int BYTES_W    = 64;
  localparam int REFILL_W   = 32;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;

  // Input word layout, lowest bit first
  localparam int SLOT_LSB = 0;
  localparam int REQ_LSB  = SLOT_LSB + SLOT_IN_W;
  localparam int BASE_LSB = REQ_LSB + SIZE_W;
  localparam int IN_USED_W = BASE_LSB + ADDR_OUT_W;
  localparam int IN_DATA_W = ((IN_USED_W + 7) / 8) * 8;

  // Output word layout, lowest bit first
  localparam int ADDR_LSB   = 0;
  localparam int RSIZE_LSB  = ADDR_LSB + ADDR_OUT_W;
  localparam int TALLOC_LSB = RSIZE_LSB + SIZE_W;
  localparam int TREF_LSB   = TALLOC_LSB + BYTES_W;
  localparam int OUT_USED_W = TREF_LSB + REFILL_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // Allocation granule and adaptive sizing threshold
  localparam int ALIGN_MASK       = 7;
  localparam int REFILL_THRESHOLD = 10;

  // Register reset values
  localparam int DEFAULT_SIZE_RST = 32 * 1024;
  localparam int MAX_SIZE_RST     = 256 * 1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_REFILL = 2'd1,
    CMD_RETIRE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOROOM = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FAIL   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADAPT   = 2'd2;

endpackage

### hw/rtl/ptba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ptba_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/per_thread_bump_allocator.sv
// Per-thread bump allocator: region table in RAM with read-modify-write control.
//
// Commands arrive on the s_ channel, one word each: s_tuser carries the command
// (allocate, refill, retire all, size query), s_tdata the slot, request size and
// chunk base. Each command yields exactly one result word on the m_ channel:
// m_tuser carries the status, m_tdata the address, region size and the two
// running totals taken after the command.
// Region cursor and end sit in one RAM, per-thread statistics in another; each
// RAM has a flip-flop valid bit per slot, so reset and retire-all take effect at
// once with no clearing pass. Retire-all drops only the region valid bits.
// The accepting edge reads both RAMs, the next cycle (ST_MUL) registers the read
// data and the product used for the average-size test, and ST_WB decides, writes
// back and loads the output register. m_tvalid rises at the edge that loads the
// output register and s_tready returns at that same edge, so the block takes a new
// command only after the last one has finished its read, multiply and write-back.
// A result waiting in the output register does not block acceptance of the next
// command; if the receiver still stalls when that command is ready to write
// back, the block holds it until the output register frees.
// Configuration writes on cfg_we take effect at once; the user issues them only
// while no command is in flight, which the block does not enforce. Reset (rst,
// synchronous) empties the table, clears the totals and restores register defaults.
module per_thread_bump_allocator #(
  parameter int THREAD_SLOTS = ptba_pkg::THREAD_SLOTS_DEF,
  parameter int ADDR_BITS    = ptba_pkg::ADDR_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [ptba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptba_pkg::SIZE_W-1:0]        cfg_data,
  // command channel
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // tdata: thread_slot[3:0], request_bytes[28:4], chunk_base[76:29], zero fill
  input  logic [ptba_pkg::IN_DATA_W-1:0]     s_tdata,
  // tuser: cmd[1:0]
  input  logic [ptba_pkg::CMD_W-1:0]         s_tuser,
  // result channel
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // tdata: address[47:0], region_size[72:48], total_allocated[136:73],
  //        total_refills[168:137], zero fill
  output logic [ptba_pkg::OUT_DATA_W-1:0]    m_tdata,
  // tuser: status[1:0]
  output logic [ptba_pkg::STATUS_W-1:0]      m_tuser
);

  localparam int SLOT_W = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int SW     = ptba_pkg::SIZE_W;
  localparam int RBW    = SW + 1;                          // rounded request
  localparam int BW     = ptba_pkg::BYTES_W;
  localparam int RW     = ptba_pkg::REFILL_W;
  localparam int AOW    = ptba_pkg::ADDR_OUT_W;
  localparam int PW     = RBW + RW;                        // average test product
  localparam int CW     = ((ADDR_BITS > RBW) ? ADDR_BITS : RBW) + 1;
  localparam int REG_W  = 2 * ADDR_BITS;
  localparam int STAT_W = BW + RW;
  localparam int SLOTS_SEEN = 1 << ptba_pkg::SLOT_IN_W;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_WB} state_t;

  state_t state;

  // configuration registers
  logic [SW-1:0] def_size;
  logic [SW-1:0] max_size;
  logic          adaptive;

  // latched command
  ptba_pkg::cmd_t        cmd_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [SW-1:0]         req_q;
  logic [ADDR_BITS-1:0]  base_q;

  // registered table entry and product
  logic [ADDR_BITS-1:0]  cur_q;
  logic [ADDR_BITS-1:0]  end_q;
  logic [BW-1:0]         tb_q;
  logic [RW-1:0]         tr_q;
  logic [PW-1:0]         prod_q;

  // running totals and valid bits
  logic [BW-1:0]           sum_bytes;
  logic [RW-1:0]           sum_refills;
  logic [THREAD_SLOTS-1:0] live;
  logic [THREAD_SLOTS-1:0] stat_valid;

  // RAM ports
  logic [REG_W-1:0]  reg_rdata;
  logic [STAT_W-1:0] stat_rdata;
  logic              reg_we;
  logic [REG_W-1:0]  reg_wdata;
  logic              stat_we;
  logic [STAT_W-1:0] stat_wdata;

  // input unpacking
  logic [ptba_pkg::SLOT_IN_W-1:0] in_slot;
  logic [SLOT_W-1:0]              in_slot_idx;
  logic                           in_acc;

  assign in_slot = s_tdata[ptba_pkg::SLOT_LSB +: ptba_pkg::SLOT_IN_W];
  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;

  // Fold the slot into the table: one constant entry per possible slot code
  always_comb begin
    in_slot_idx = '0;
    for (int i = 0; i < SLOTS_SEEN; i++) begin
      if (in_slot == ptba_pkg::SLOT_IN_W'(i)) begin
        in_slot_idx = SLOT_W'(i % THREAD_SLOTS);
      end
    end
  end

  // Region table: {end, cursor}
  ptba_ram #(.WIDTH(REG_W), .DEPTH(THREAD_SLOTS)) u_region_ram (
    .clk   (clk),
    .we    (reg_we),
    .waddr (slot_q),
    .wdata (reg_wdata),
    .re    (in_acc),
    .raddr (in_slot_idx),
    .rdata (reg_rdata)
  );

  // Statistics table: {refills, bytes}
  ptba_ram #(.WIDTH(STAT_W), .DEPTH(THREAD_SLOTS)) u_stat_ram (
    .clk   (clk),
    .we    (stat_we),
    .waddr (slot_q),
    .wdata (stat_wdata),
    .re    (in_acc),
    .raddr (in_slot_idx),
    .rdata (stat_rdata)
  );

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      def_size <= SW'(ptba_pkg::DEFAULT_SIZE_RST);
      max_size <= SW'(ptba_pkg::MAX_SIZE_RST);
      adaptive <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        ptba_pkg::CFG_DEFAULT: def_size <= cfg_data;
        ptba_pkg::CFG_MAX:     max_size <= cfg_data;
        ptba_pkg::CFG_ADAPT:   adaptive <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Latch the command word on acceptance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_q  <= ptba_pkg::cmd_t'(s_tuser);
      slot_q <= in_slot_idx;
      req_q  <= s_tdata[ptba_pkg::REQ_LSB +: SW];
      base_q <= ADDR_BITS'(s_tdata[ptba_pkg::BASE_LSB +: AOW]);
    end
  end

  // Read stage: mask entries that are not valid, form (default + 1) * refills
  logic [ADDR_BITS-1:0] cur_m;
  logic [ADDR_BITS-1:0] end_m;
  logic [BW-1:0]        tb_m;
  logic [RW-1:0]        tr_m;
  logic [RBW-1:0]       def_plus1;

  always_comb begin
    cur_m     = live[slot_q] ? reg_rdata[ADDR_BITS-1:0] : '0;
    end_m     = live[slot_q] ? reg_rdata[REG_W-1:ADDR_BITS] : '0;
    tb_m      = stat_valid[slot_q] ? stat_rdata[BW-1:0] : '0;
    tr_m      = stat_valid[slot_q] ? stat_rdata[STAT_W-1:BW] : '0;
    def_plus1 = RBW'(def_size) + RBW'(1);
  end

  always_ff @(posedge clk) begin
    if (state == ST_MUL) begin
      cur_q  <= cur_m;
      end_q  <= end_m;
      tb_q   <= tb_m;
      tr_q   <= tr_m;
      prod_q <= PW'(def_plus1) * PW'(tr_m);
    end
  end

  // Write-back stage
  logic                 load;
  logic [RBW-1:0]       bytes;
  logic                 fit;
  logic [ADDR_BITS-1:0] new_cur;
  logic [BW:0]          tb_sum;
  logic [BW:0]          sb_sum;
  logic [BW-1:0]        tb_new;
  logic [BW-1:0]        sb_new;
  logic                 busy;
  logic [RBW-1:0]       twice;
  logic [SW-1:0]        cap;
  logic [SW-1:0]        rsize;
  logic [CW-1:0]        end_sum;
  logic [ADDR_BITS-1:0] new_end;
  logic [RW-1:0]        tr_new;
  logic [RW-1:0]        sr_new;

  logic [ptba_pkg::STATUS_W-1:0]   status_n;
  logic [AOW-1:0]                  addr_n;
  logic [SW-1:0]                   rsize_n;
  logic [BW-1:0]                   sum_bytes_n;
  logic [RW-1:0]                   sum_refills_n;
  logic                            live_set;
  logic                            retire;
  logic [ptba_pkg::OUT_DATA_W-1:0] m_word_n;

  assign load = (state == ST_WB) && (!m_tvalid || m_tready);

  always_comb begin
    // round up to the allocation granule
    bytes   = (RBW'(req_q) + RBW'(ptba_pkg::ALIGN_MASK)) & ~RBW'(ptba_pkg::ALIGN_MASK);
    fit     = (end_q >= cur_q) && (CW'(bytes) <= CW'(end_q - cur_q));
    new_cur = cur_q + ADDR_BITS'(bytes);

    // saturating byte counters
    tb_sum = {1'b0, tb_q} + (BW + 1)'(bytes);
    sb_sum = {1'b0, sum_bytes} + (BW + 1)'(bytes);
    tb_new = tb_sum[BW] ? '1 : tb_sum[BW-1:0];
    sb_new = sb_sum[BW] ? '1 : sb_sum[BW-1:0];

    // saturating refill counters
    tr_new = (&tr_q) ? tr_q : tr_q + RW'(1);
    sr_new = (&sum_refills) ? sum_refills : sum_refills + RW'(1);

    // average above default: bytes / refills > def  <=>  bytes >= (def + 1) * refills
    busy  = adaptive && (tr_q > RW'(ptba_pkg::REFILL_THRESHOLD)) && (BW'(prod_q) <= tb_q);
    twice = {def_size, 1'b0};
    cap   = (RBW'(max_size) < twice) ? max_size : twice[SW-1:0];
    rsize = busy ? cap : def_size;

    // region end, saturated at the top of the address space
    end_sum = CW'(base_q) + CW'(rsize);
    new_end = (end_sum > CW'({ADDR_BITS{1'b1}})) ? {ADDR_BITS{1'b1}}
                                                 : end_sum[ADDR_BITS-1:0];

    status_n      = ptba_pkg::STAT_OK;
    addr_n        = '0;
    rsize_n       = '0;
    sum_bytes_n   = sum_bytes;
    sum_refills_n = sum_refills;
    reg_we        = 1'b0;
    reg_wdata     = {end_q, new_cur};
    stat_we       = 1'b0;
    stat_wdata    = {tr_q, tb_new};
    live_set      = 1'b0;
    retire        = 1'b0;

    case (cmd_q)
      ptba_pkg::CMD_ALLOC: begin
        if (fit) begin
          addr_n      = AOW'(cur_q);
          reg_we      = load;
          stat_we     = load;
          sum_bytes_n = sb_new;
        end else begin
          status_n = ptba_pkg::STAT_NOROOM;
        end
      end
      ptba_pkg::CMD_REFILL: begin
        rsize_n = rsize;
        if (base_q == '0) begin
          status_n = ptba_pkg::STAT_FAIL;
        end else begin
          reg_we        = load;
          reg_wdata     = {new_end, base_q};
          stat_we       = load;
          stat_wdata    = {tr_new, tb_q};
          live_set      = 1'b1;
          sum_refills_n = sr_new;
        end
      end
      ptba_pkg::CMD_RETIRE: begin
        retire = 1'b1;
      end
      ptba_pkg::CMD_QUERY: begin
        rsize_n = rsize;
      end
      default: ;
    endcase
  end

  // Pack the result word
  always_comb begin
    m_word_n = '0;
    m_word_n[ptba_pkg::ADDR_LSB +: AOW]  = addr_n;
    m_word_n[ptba_pkg::RSIZE_LSB +: SW]  = rsize_n;
    m_word_n[ptba_pkg::TALLOC_LSB +: BW] = sum_bytes_n;
    m_word_n[ptba_pkg::TREF_LSB +: RW]   = sum_refills_n;
  end

  // Totals and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_bytes   <= '0;
      sum_refills <= '0;
      live        <= '0;
      stat_valid  <= '0;
    end else if (load) begin
      sum_bytes   <= sum_bytes_n;
      sum_refills <= sum_refills_n;
      if (retire) begin
        live <= '0;
      end else if (live_set) begin
        live[slot_q] <= 1'b1;
      end
      if (stat_we) begin
        stat_valid[slot_q] <= 1'b1;
      end
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_WB;
        end
        ST_WB: begin
          // hold until the output register is free
          if (load) begin
            state   <= ST_IDLE;
            m_tuser <= status_n;
            m_tdata <= m_word_n;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/ptba_checker.sv
// Port-level checks for the per-thread bump allocator, bound to the top level.
module ptba_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             cfg_we,
  input logic [ptba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [ptba_pkg::SIZE_W-1:0]      cfg_data,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [ptba_pkg::IN_DATA_W-1:0]   s_tdata,
  input logic [ptba_pkg::CMD_W-1:0]       s_tuser,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [ptba_pkg::OUT_DATA_W-1:0]  m_tdata,
  input logic [ptba_pkg::STATUS_W-1:0]    m_tuser
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // Only one command is in flight: ready drops after each acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("command accepted while another is in flight");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

  // Status is always a defined code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ptba_pkg::STAT_OK) || (m_tuser == ptba_pkg::STAT_NOROOM) ||
                 (m_tuser == ptba_pkg::STAT_FAIL))
    else $error("undefined status code");

  // A failed command returns no address; no room also reports no size
  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ptba_pkg::STAT_OK) |->
      (m_tdata[ptba_pkg::ADDR_LSB +: ptba_pkg::ADDR_OUT_W] == '0) &&
      ((m_tuser != ptba_pkg::STAT_NOROOM) ||
       (m_tdata[ptba_pkg::RSIZE_LSB +: ptba_pkg::SIZE_W] == '0)))
    else $error("failed command returned an address");

endmodule

bind per_thread_bump_allocator ptba_checker u_ptba_checker (.*);

### tb/per_thread_bump_allocator_test.sv
// Self-checking testbench for the per-thread bump allocator: directed table, then random traffic.
//
// A command word is predicted at the edge that accepts it. The expected result
// is queued and later compared, field by field, with each result word that
// leaves the block. Configuration changes only while nothing is in flight.
module per_thread_bump_allocator_test;

  localparam int          SLOTS    = ptba_pkg::THREAD_SLOTS_DEF;
  localparam logic [63:0] ADDR_TOP = (64'd1 << ptba_pkg::ADDR_OUT_W) - 64'd1;
  localparam int          RANDOM_WORDS_PER_PHASE = 95;

  // One result word, as it leaves the block
  typedef struct packed {
    logic [ptba_pkg::STATUS_W-1:0]   status;
    logic [ptba_pkg::ADDR_OUT_W-1:0] address;
    logic [ptba_pkg::SIZE_W-1:0]     region_size;
    logic [ptba_pkg::BYTES_W-1:0]    total_allocated;
    logic [ptba_pkg::REFILL_W-1:0]   total_refills;
  } alloc_result_t;

  // One directed command; pinned rows carry a result typed in by hand
  typedef struct packed {
    ptba_pkg::cmd_t                  cmd;
    logic [ptba_pkg::SLOT_IN_W-1:0]  slot;
    logic [ptba_pkg::SIZE_W-1:0]     req;
    logic [ptba_pkg::ADDR_OUT_W-1:0] base;
    bit                              pinned;
    alloc_result_t                   pinned_result;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 23;
  localparam directed_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
    // empty table straight after reset: only a zero-byte request fits
    '{ptba_pkg::CMD_ALLOC,  4'd0,  25'd0,        48'd0,            1'b1,
      '{ptba_pkg::STAT_OK,     48'd0, 25'd0,     64'd0, 32'd0}},
    '{ptba_pkg::CMD_ALLOC,  4'd5,  25'd1,        48'd0,            1'b1,
      '{ptba_pkg::STAT_NOROOM, 48'd0, 25'd0,     64'd0, 32'd0}},
    '{ptba_pkg::CMD_QUERY,  4'd15, 25'h1FFFFFF,  48'hFFFF_FFFF_FFFF, 1'b1,
      '{ptba_pkg::STAT_OK,     48'd0, 25'd32768, 64'd0, 32'd0}},
    // zero chunk fails but still reports the size
    '{ptba_pkg::CMD_REFILL, 4'd3,  25'd0,        48'd0,            1'b1,
      '{ptba_pkg::STAT_FAIL,   48'd0, 25'd32768, 64'd0, 32'd0}},
    '{ptba_pkg::CMD_REFILL, 4'd3,  25'h1FFFFFF,  48'h1000,         1'b1,
      '{ptba_pkg::STAT_OK,     48'd0, 25'd32768, 64'd0, 32'd1}},
    '{ptba_pkg::CMD_ALLOC,  4'd3,  25'd1,        48'd0,            1'b1,
      '{ptba_pkg::STAT_OK,     48'h1000, 25'd0,  64'd8, 32'd1}},
    '{ptba_pkg::CMD_ALLOC,  4'd3,  25'd0,        48'd0,            1'b0, '0},
    '{ptba_pkg::CMD_ALLOC,  4'd3,  25'h1FFFFFF,  48'd0,            1'b1,
      '{ptba_pkg::STAT_NOROOM, 48'd0, 25'd0,     64'd8, 32'd1}},
    // fill the region exactly, then overflow it by one granule
    '{ptba_pkg::CMD_ALLOC,  4'd3,  25'd32760,    48'd0,            1'b0, '0},
    '{ptba_pkg::CMD_ALLOC,  4'd3,  25'd1,        48'd0,            1'b0, '0},
    // region end clamps at the top of the address space
    '{ptba_pkg::CMD_REFILL, 4'd15, 25'd0,        48'hFFFF_FFFF_FFF0, 1'b0, '0},
    '{ptba_pkg::CMD_ALLOC,  4'd15, 25'd9,        48'd0,            1'b0, '0},
    '{ptba_pkg::CMD_ALLOC,  4'd15, 25'd8,        48'd0,            1'b0, '0},
    '{ptba_pkg::CMD_REFILL, 4'd0,  25'd0,        48'hFFFF_FFFF_FFFF, 1'b0, '0},
    '{ptba_pkg::CMD_ALLOC,  4'd0,  25'd0,        48'd0,            1'b0, '0},
    '{ptba_pkg::CMD_ALLOC,  4'd0,  25'd7,        48'd0,            1'b0, '0},
    // retire everything, statistics stay
    '{ptba_pkg::CMD_RETIRE, 4'd7,  25'h1FFFFFF,  48'hFFFF_FFFF_FFFF, 1'b0, '0},
    '{ptba_pkg::CMD_ALLOC,  4'd3,  25'd0,        48'd0,            1'b0, '0},
    '{ptba_pkg::CMD_ALLOC,  4'd15, 25'd8,        48'd0,            1'b0, '0},
    '{ptba_pkg::CMD_QUERY,  4'd3,  25'd0,        48'd0,            1'b0, '0},
    '{ptba_pkg::CMD_REFILL, 4'd8,  25'h1FFFFFF,  48'd1,            1'b0, '0},
    '{ptba_pkg::CMD_ALLOC,  4'd8,  25'd16777216, 48'd0,            1'b0, '0},
    '{ptba_pkg::CMD_ALLOC,  4'd8,  25'd32767,    48'd0,            1'b0, '0}
  };

  // Settings for the random phases; phase 0 keeps the reset values
  localparam logic [ptba_pkg::SIZE_W-1:0] PHASE_DEFAULT [4] =
    '{25'd32768, 25'd8, 25'h1FFFFFF, 25'd4096};
  localparam logic [ptba_pkg::SIZE_W-1:0] PHASE_MAX [4] =
    '{25'd262144, 25'd16777216, 25'd8, 25'd6000};
  localparam logic PHASE_ADAPT [4] = '{1'b1, 1'b1, 1'b0, 1'b1};

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [ptba_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ptba_pkg::SIZE_W-1:0]     cfg_data;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [ptba_pkg::IN_DATA_W-1:0]  s_tdata;
  logic [ptba_pkg::CMD_W-1:0]      s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [ptba_pkg::OUT_DATA_W-1:0] m_tdata;
  logic [ptba_pkg::STATUS_W-1:0]   m_tuser;

  // Predicted copy of the region table, statistics and registers
  logic [63:0]                   shadow_cursor [SLOTS];
  logic [63:0]                   shadow_end [SLOTS];
  logic [ptba_pkg::BYTES_W-1:0]  shadow_bytes [SLOTS];
  logic [ptba_pkg::REFILL_W-1:0] shadow_refills [SLOTS];
  logic [ptba_pkg::BYTES_W-1:0]  shadow_bytes_sum;
  logic [ptba_pkg::REFILL_W-1:0] shadow_refills_sum;
  logic [ptba_pkg::SIZE_W-1:0]   shadow_default;
  logic [ptba_pkg::SIZE_W-1:0]   shadow_max;
  logic                          shadow_adapt;

  alloc_result_t pending_results [$];
  int            mismatch_count;
  int            words_sent;
  int            report_lines;

  per_thread_bump_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // Hard stop in case the block locks up
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [ptba_pkg::BYTES_W-1:0] sat_add_bytes(
      input logic [ptba_pkg::BYTES_W-1:0] a, input logic [63:0] b);
    logic [ptba_pkg::BYTES_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[ptba_pkg::BYTES_W] ? '1 : sum[ptba_pkg::BYTES_W-1:0];
  endfunction

  function automatic logic [ptba_pkg::REFILL_W-1:0] sat_inc_refills(
      input logic [ptba_pkg::REFILL_W-1:0] a);
    return (a == '1) ? a : a + 1'b1;
  endfunction

  // Region size a refill or size query would use for this slot
  function automatic logic [ptba_pkg::SIZE_W-1:0] region_size_for(
      input logic [ptba_pkg::SLOT_IN_W-1:0] slot);
    logic [ptba_pkg::SIZE_W:0] doubled;
    if (!shadow_adapt)
      return shadow_default;
    if (shadow_refills[slot] > ptba_pkg::REFILL_THRESHOLD &&
        (shadow_bytes[slot] / shadow_refills[slot]) > {39'd0, shadow_default}) begin
      doubled = {shadow_default, 1'b0};
      return ({1'b0, shadow_max} < doubled) ? shadow_max : doubled[ptba_pkg::SIZE_W-1:0];
    end
    return shadow_default;
  endfunction

  // Work out the result of one accepted command and advance the shadow state
  function automatic alloc_result_t predict_result(
      input ptba_pkg::cmd_t cmd,
      input logic [ptba_pkg::SLOT_IN_W-1:0] slot,
      input logic [ptba_pkg::SIZE_W-1:0] req,
      input logic [ptba_pkg::ADDR_OUT_W-1:0] base);
    alloc_result_t r;
    logic [63:0]   rounded;
    logic [63:0]   base64;
    r = '0;
    base64 = {{(64-ptba_pkg::ADDR_OUT_W){1'b0}}, base};
    case (cmd)
      ptba_pkg::CMD_ALLOC: begin
        rounded = ({39'd0, req} + 64'd7) & ~64'd7;
        if (shadow_end[slot] < shadow_cursor[slot] ||
            rounded > shadow_end[slot] - shadow_cursor[slot]) begin
          r.status = ptba_pkg::STAT_NOROOM;
        end else begin
          r.address = shadow_cursor[slot][ptba_pkg::ADDR_OUT_W-1:0];
          shadow_cursor[slot] = shadow_cursor[slot] + rounded;
          shadow_bytes[slot] = sat_add_bytes(shadow_bytes[slot], rounded);
          shadow_bytes_sum = sat_add_bytes(shadow_bytes_sum, rounded);
        end
      end
      ptba_pkg::CMD_REFILL: begin
        r.region_size = region_size_for(slot);
        if (base == '0) begin
          r.status = ptba_pkg::STAT_FAIL;
        end else begin
          shadow_cursor[slot] = base64;
          // clamp the end at the top of the address space
          shadow_end[slot] = ({39'd0, r.region_size} > ADDR_TOP - base64) ?
                             ADDR_TOP : base64 + {39'd0, r.region_size};
          shadow_refills[slot] = sat_inc_refills(shadow_refills[slot]);
          shadow_refills_sum = sat_inc_refills(shadow_refills_sum);
        end
      end
      ptba_pkg::CMD_RETIRE: begin
        for (int i = 0; i < SLOTS; i++) begin
          shadow_cursor[i] = '0;
          shadow_end[i] = '0;
        end
      end
      default: begin
        r.region_size = region_size_for(slot);
      end
    endcase
    r.total_allocated = shadow_bytes_sum;
    r.total_refills = shadow_refills_sum;
    return r;
  endfunction

  // Offer one command word, hold it until taken, then queue what it should yield
  task automatic issue_command(input ptba_pkg::cmd_t cmd,
                               input logic [ptba_pkg::SLOT_IN_W-1:0] slot,
                               input logic [ptba_pkg::SIZE_W-1:0] req,
                               input logic [ptba_pkg::ADDR_OUT_W-1:0] base,
                               input bit pinned, input alloc_result_t pinned_result);
    logic [ptba_pkg::IN_DATA_W-1:0] word;
    alloc_result_t                  predicted;
    // a run of words goes through with no gaps at all
    if (words_sent < 250 || words_sent > 330) begin
      while ($urandom_range(99) < 9) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    word = '0;
    word[ptba_pkg::SLOT_LSB +: ptba_pkg::SLOT_IN_W] = slot;
    word[ptba_pkg::REQ_LSB +: ptba_pkg::SIZE_W] = req;
    word[ptba_pkg::BASE_LSB +: ptba_pkg::ADDR_OUT_W] = base;
    s_tvalid <= 1'b1;
    s_tdata <= word;
    s_tuser <= cmd;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    predicted = predict_result(cmd, slot, req, base);
    pending_results.insert(pending_results.size(), pinned ? pinned_result : predicted);
  endtask

  // Drop valid and hold until every outstanding result has been seen
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Write all three registers back to back; the block is idle here
  task automatic set_config(input logic [ptba_pkg::SIZE_W-1:0] dflt,
                            input logic [ptba_pkg::SIZE_W-1:0] maxs,
                            input logic adapt);
    logic [31:0] junk;
    junk = $urandom;
    cfg_we <= 1'b1;
    cfg_index <= ptba_pkg::CFG_DEFAULT;
    cfg_data <= dflt;
    @(posedge clk);
    cfg_index <= ptba_pkg::CFG_MAX;
    cfg_data <= maxs;
    @(posedge clk);
    // upper bits of the enable write are don't-care
    cfg_index <= ptba_pkg::CFG_ADAPT;
    cfg_data <= {junk[ptba_pkg::SIZE_W-2:0], adapt};
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_default = dflt;
    shadow_max = maxs;
    shadow_adapt = adapt;
  endtask

  // Favour two slots so that their refill counts pass the adaptive threshold
  function automatic logic [ptba_pkg::SLOT_IN_W-1:0] pick_slot();
    int unsigned roll;
    logic [31:0] pick;
    roll = $urandom_range(99);
    if (roll < 45)
      return '0;
    if (roll < 70)
      return 4'd1;
    pick = $urandom_range(SLOTS - 1);
    return pick[ptba_pkg::SLOT_IN_W-1:0];
  endfunction

  function automatic logic [ptba_pkg::ADDR_OUT_W-1:0] pick_base();
    int unsigned roll;
    logic [63:0] wide;
    roll = $urandom_range(99);
    wide = {$urandom, $urandom};
    if (roll < 6)
      return '0;
    if (roll < 12)
      return ADDR_TOP[ptba_pkg::ADDR_OUT_W-1:0] - $urandom_range(70000);
    return wide[ptba_pkg::ADDR_OUT_W-1:0];
  endfunction

  // Request sized against the current default so most fit and some overrun
  function automatic logic [ptba_pkg::SIZE_W-1:0] pick_request();
    int unsigned hint;
    logic [31:0] wide;
    wide = $urandom;
    if ($urandom_range(99) < 5)
      return wide[ptba_pkg::SIZE_W-1:0];
    hint = (shadow_default > 25'd65536) ? 65536 : shadow_default;
    wide = $urandom_range(hint / 2 + 8);
    return wide[ptba_pkg::SIZE_W-1:0];
  endfunction

  initial begin : stimulus
    int unsigned   roll;
    int unsigned   burst;
    int            made;
    logic [ptba_pkg::SLOT_IN_W-1:0] slot;
    logic [31:0]   noise;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= ptba_pkg::CMD_ALLOC;
    cfg_we <= 1'b0;
    cfg_index <= ptba_pkg::CFG_DEFAULT;
    cfg_data <= '0;
    words_sent = 0;
    mismatch_count = 0;
    report_lines = 0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_cursor[i] = '0;
      shadow_end[i] = '0;
      shadow_bytes[i] = '0;
      shadow_refills[i] = '0;
    end
    shadow_bytes_sum = '0;
    shadow_refills_sum = '0;
    shadow_default = ptba_pkg::DEFAULT_SIZE_RST[ptba_pkg::SIZE_W-1:0];
    shadow_max = ptba_pkg::MAX_SIZE_RST[ptba_pkg::SIZE_W-1:0];
    shadow_adapt = 1'b1;

    do @(posedge clk); while (rst);

    // walk the directed table under the reset settings
    for (int i = 0; i < DIRECTED_ROWS; i++)
      issue_command(DIRECTED_TABLE[i].cmd, DIRECTED_TABLE[i].slot, DIRECTED_TABLE[i].req,
                    DIRECTED_TABLE[i].base, DIRECTED_TABLE[i].pinned,
                    DIRECTED_TABLE[i].pinned_result);

    for (int ph = 0; ph < 4; ph++) begin
      if (ph > 0) begin
        drain_results();
        set_config(PHASE_DEFAULT[ph], PHASE_MAX[ph], PHASE_ADAPT[ph]);
      end
      made = 0;
      while (made < RANDOM_WORDS_PER_PHASE) begin
        roll = $urandom_range(99);
        slot = pick_slot();
        if (roll < 60) begin
          // refill, then carve allocations from it with the odd size query
          issue_command(ptba_pkg::CMD_REFILL, slot, pick_request(), pick_base(), 1'b0, '0);
          burst = $urandom_range(1, 4);
          for (int k = 0; k < burst; k++) begin
            if ($urandom_range(99) < 12)
              issue_command(ptba_pkg::CMD_QUERY, slot, pick_request(), pick_base(),
                            1'b0, '0);
            else
              issue_command(ptba_pkg::CMD_ALLOC, slot, pick_request(), pick_base(),
                            1'b0, '0);
          end
          made += burst + 1;
        end else if (roll < 63) begin
          issue_command(ptba_pkg::CMD_RETIRE, slot, pick_request(), pick_base(), 1'b0, '0);
          made++;
        end else if (roll < 80) begin
          issue_command(ptba_pkg::CMD_ALLOC, slot, pick_request(), pick_base(), 1'b0, '0);
          made++;
        end else begin
          // anything at all, fields at full width
          noise = $urandom;
          issue_command(ptba_pkg::cmd_t'(noise[1:0]), noise[5:2], noise[30:6], pick_base(),
                        1'b0, '0);
          made++;
        end
      end
    end

    drain_results();
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Receiver: random back-pressure, one quiet stretch, and one long hold-off
  initial begin : receiver
    int  cycle_count;
    bit  held_off;
    cycle_count = 0;
    held_off = 1'b0;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      cycle_count++;
      if (!held_off && words_sent >= 150) begin
        // hold off long enough for the block to fill and stall its input
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (80) @(posedge clk);
      end else begin
        if (cycle_count >= 700 && cycle_count < 1100)
          m_tready <= 1'b1;
        else
          m_tready <= ($urandom_range(99) >= 9);
        @(posedge clk);
      end
    end
  end

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      // cap the log if the block is badly off
      if (report_lines < 200) begin
        report_lines++;
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      end
    end
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin : result_check
    alloc_result_t seen;
    alloc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      seen.status = m_tuser;
      seen.address = m_tdata[ptba_pkg::ADDR_LSB +: ptba_pkg::ADDR_OUT_W];
      seen.region_size = m_tdata[ptba_pkg::RSIZE_LSB +: ptba_pkg::SIZE_W];
      seen.total_allocated = m_tdata[ptba_pkg::TALLOC_LSB +: ptba_pkg::BYTES_W];
      seen.total_refills = m_tdata[ptba_pkg::TREF_LSB +: ptba_pkg::REFILL_W];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result word expected none, got status %0h address %0h",
                 $time, seen.status, seen.address);
      end else begin
        want = pending_results.pop_front();
        compare_field("status", 64'(want.status), 64'(seen.status));
        compare_field("address", 64'(want.address), 64'(seen.address));
        compare_field("region_size", 64'(want.region_size), 64'(seen.region_size));
        compare_field("total_allocated", want.total_allocated, seen.total_allocated);
        compare_field("total_refills", 64'(want.total_refills), 64'(seen.total_refills));
      end
    end
  end

endmodule
